// ===== rtl/stack_machine_execute_unit_defines.svh =====
// Assertion macros for the stack machine execute unit
`ifndef STACK_MACHINE_EXECUTE_UNIT_DEFINES_SVH
`define STACK_MACHINE_EXECUTE_UNIT_DEFINES_SVH
`ifndef NO_ASSERTIONS
`define SMEU_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error("smeu assertion failed");
`define SMEU_ASSERT_ALWAYS(lbl, prop) \
  lbl: assert property (@(posedge clk_i) (prop)) \
    else $error("smeu assertion failed");
`else
`define SMEU_ASSERT(lbl, prop)
`define SMEU_ASSERT_ALWAYS(lbl, prop)
`endif
`endif

// ===== rtl/smeu_pkg.sv =====
// Shared types and constants of the stack machine execute unit
`default_nettype none
package smeu_pkg;
  localparam int DEPTH_DEF     = 256;
  localparam int WORD_BITS_DEF = 32;
  localparam int OPND_W        = 32;
  localparam int CMD_W         = 5;
  localparam int STATUS_W      = 3;
  localparam int CNT_OUT_W     = 9;

  typedef enum logic [CMD_W-1:0] {
    CMD_PUSH = 5'd0,  CMD_ADD  = 5'd1,  CMD_SUB  = 5'd2,  CMD_MUL  = 5'd3,
    CMD_DIV  = 5'd4,  CMD_CLR  = 5'd5,  CMD_SWAP = 5'd6,  CMD_NEG  = 5'd7,
    CMD_DUP  = 5'd8,  CMD_OUT  = 5'd9,  CMD_HALT = 5'd10, CMD_NOP  = 5'd11,
    CMD_NOT  = 5'd12, CMD_GTR  = 5'd13, CMD_LESS = 5'd14, CMD_EQ   = 5'd15,
    CMD_LDA  = 5'd16, CMD_JMPZ = 5'd17, CMD_STO  = 5'd18, CMD_JMP  = 5'd19
  } cmd_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK        = 3'd0,
    ST_UNDERFLOW = 3'd1,
    ST_DIV_ZERO  = 3'd2,
    ST_FULL      = 3'd3,
    ST_BAD_ADDR  = 3'd4,
    ST_HALTED    = 3'd5,
    ST_ILLEGAL   = 3'd6
  } status_e;

  typedef struct packed {
    logic start;
    logic is_div;
  } arith_req_t;

  typedef struct packed {
    status_e               status;
    logic                  out_valid;
    logic [OPND_W-1:0]     out_value;
    logic                  jump_taken;
    logic [OPND_W-1:0]     jump_label;
    logic [CNT_OUT_W-1:0]  entry_count;
    logic                  is_halted;
  } res_t;
endpackage
`default_nettype wire

// ===== rtl/smeu_ram.sv =====
// Generic single-write, single-read RAM with registered read data
`default_nettype none
module smeu_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);
  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end
endmodule
`default_nettype wire

// ===== rtl/smeu_arith.sv =====
// Bit-serial multiplier and restoring divider shared by mul and div
`default_nettype none
module smeu_arith
  import smeu_pkg::*;
#(
  parameter int WIDTH = WORD_BITS_DEF
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire arith_req_t       req_i,
  input  wire logic [WIDTH-1:0] a_i,
  input  wire logic [WIDTH-1:0] b_i,
  output logic                  done_o,
  output logic      [WIDTH-1:0] result_o
);
  localparam int STEP_W = $clog2(WIDTH);

  logic              run_q, done_q, div_q, neg_q;
  logic [STEP_W-1:0] step_q;
  logic [WIDTH-1:0]  acc_q, x_q, y_q;
  logic [WIDTH:0]    sh, diff;
  logic [WIDTH-1:0]  abs_a, abs_b;

  assign abs_a = a_i[WIDTH-1] ? ('0 - a_i) : a_i;
  assign abs_b = b_i[WIDTH-1] ? ('0 - b_i) : b_i;
  assign sh    = {acc_q, x_q[WIDTH-1]};
  assign diff  = sh - {1'b0, y_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      done_q <= 1'b0;
      step_q <= '0;
    end else begin
      done_q <= 1'b0;
      if (req_i.start) begin
        run_q  <= 1'b1;
        div_q  <= req_i.is_div;
        step_q <= '0;
        acc_q  <= '0;
        neg_q  <= a_i[WIDTH-1] ^ b_i[WIDTH-1];
        x_q    <= req_i.is_div ? abs_a : a_i;
        y_q    <= req_i.is_div ? abs_b : b_i;
      end else if (run_q) begin
        if (div_q) begin
          if (!diff[WIDTH]) begin
            acc_q <= diff[WIDTH-1:0];
            x_q   <= {x_q[WIDTH-2:0], 1'b1};
          end else begin
            acc_q <= sh[WIDTH-1:0];
            x_q   <= {x_q[WIDTH-2:0], 1'b0};
          end
        end else begin
          if (y_q[0]) begin
            acc_q <= acc_q + x_q;
          end
          x_q <= {x_q[WIDTH-2:0], 1'b0};
          y_q <= {1'b0, y_q[WIDTH-1:1]};
        end
        step_q <= step_q + STEP_W'(1);
        if (step_q == STEP_W'(WIDTH - 1)) begin
          run_q  <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  assign done_o   = done_q;
  assign result_o = div_q ? (neg_q ? ('0 - x_q) : x_q) : acc_q;
endmodule
`default_nettype wire

// ===== rtl/stack_machine_execute_unit.sv =====
// Stack machine execute unit: sequencer around a duplicated stack RAM
//
//   channel  signals                                  direction
//   instr    instr_valid_i instr_stall_o cmd operand  in
//   res      res_valid_o res_stall_i status ... halt  out
//
// Most words are accepted with the RAM read, then executed and written back.
// mul and div run in the serial arithmetic unit; swap adds a second write state.
// After reset the RAM is zeroed entry by entry with instr_stall_o high.
// A result waiting under res_stall_i holds the sequencer once the next is done.
`default_nettype none
`include "stack_machine_execute_unit_defines.svh"
module stack_machine_execute_unit
  import smeu_pkg::*;
#(
  parameter int DEPTH     = DEPTH_DEF,
  parameter int WORD_BITS = WORD_BITS_DEF
) (
  input  wire logic                     clk_i,
  input  wire logic                     rst_ni,
  input  wire logic                     instr_valid_i,
  output logic                          instr_stall_o,
  input  wire logic [CMD_W-1:0]         cmd_i,
  input  wire logic signed [OPND_W-1:0] operand_i,
  output logic                          res_valid_o,
  input  wire logic                     res_stall_i,
  output logic [STATUS_W-1:0]           status_o,
  output logic                          out_valid_o,
  output logic signed [OPND_W-1:0]      out_value_o,
  output logic                          jump_taken_o,
  output logic signed [OPND_W-1:0]      jump_label_o,
  output logic [CNT_OUT_W-1:0]          entry_count_o,
  output logic                          is_halted_o
);
  localparam int ADDR_W = $clog2(DEPTH);
  localparam int CNT_W  = $clog2(DEPTH + 1);

  typedef enum logic [2:0] {
    S_CLEAR, S_IDLE, S_EXEC, S_ARITH, S_SWAP2, S_HOLD
  } state_e;

  state_e                state_q, state_d;
  logic [ADDR_W-1:0]     clr_idx_q;
  logic [CNT_W-1:0]      count_q, count_d;
  logic                  halted_q, halted_d;
  logic [CMD_W-1:0]      cmd_q;
  logic [OPND_W-1:0]     opnd_q;
  logic [WORD_BITS-1:0]  t_q;
  res_t                  res_q, out_q, ex_res, fin_res;
  logic                  res_vld_q, fin_vld, slot_free;

  logic [CNT_W-1:0]      cnt_m1, cnt_m2;
  logic [ADDR_W-1:0]     top_idx, nx_idx, push_idx, lda_idx, sto_idx;
  logic [OPND_W:0]       op_ext;
  logic                  addr_ok, full;
  logic [OPND_W-1:0]     op_m1;
  logic [WORD_BITS-1:0]  t, nx, opw, r;
  logic [WORD_BITS+OPND_W-1:0] t_ext;
  logic [CNT_W+CNT_OUT_W-1:0]  cnt_ext;
  logic [1:0]            need;

  logic                  ex_we, ex_arith, ex_div, ex_swap;
  logic [ADDR_W-1:0]     ex_wa;
  logic [WORD_BITS-1:0]  ex_wd;

  logic                  we;
  logic [ADDR_W-1:0]     wa, ra0, ra1;
  logic [WORD_BITS-1:0]  wd;

  arith_req_t            ar_req;
  logic                  ar_done;
  logic [WORD_BITS-1:0]  ar_res;

  smeu_ram #(.WIDTH(WORD_BITS), .DEPTH(DEPTH)) u_ram_top (
    .clk_i, .we_i(we), .waddr_i(wa), .wdata_i(wd), .raddr_i(ra0), .rdata_o(t)
  );
  smeu_ram #(.WIDTH(WORD_BITS), .DEPTH(DEPTH)) u_ram_nxt (
    .clk_i, .we_i(we), .waddr_i(wa), .wdata_i(wd), .raddr_i(ra1), .rdata_o(nx)
  );
  smeu_arith #(.WIDTH(WORD_BITS)) u_arith (
    .clk_i, .rst_ni, .req_i(ar_req), .a_i(t), .b_i(nx),
    .done_o(ar_done), .result_o(ar_res)
  );

  assign cnt_m1   = count_q - CNT_W'(1);
  assign cnt_m2   = count_q - CNT_W'(2);
  assign top_idx  = cnt_m1[ADDR_W-1:0];
  assign nx_idx   = cnt_m2[ADDR_W-1:0];
  assign push_idx = count_q[ADDR_W-1:0];
  assign full     = (count_q == CNT_W'(DEPTH));
  assign op_m1    = operand_i - OPND_W'(1);
  assign lda_idx  = op_m1[ADDR_W-1:0];
  assign ra0      = (cmd_i == CMD_LDA) ? lda_idx : top_idx;
  assign ra1      = nx_idx;

  assign op_ext   = {1'b0, opnd_q};
  assign addr_ok  = !opnd_q[OPND_W-1] && (opnd_q != '0) &&
                    (op_ext <= (OPND_W+1)'(DEPTH));
  assign sto_idx  = ADDR_W'(opnd_q - OPND_W'(1));
  assign opw      = WORD_BITS'($signed(opnd_q));
  assign t_ext    = {{OPND_W{1'b0}}, t};

  always_comb begin
    need = 2'd0;
    case (cmd_q)
      CMD_ADD, CMD_SUB, CMD_MUL, CMD_DIV, CMD_SWAP, CMD_GTR, CMD_LESS, CMD_EQ:
        need = 2'd2;
      CMD_NEG, CMD_NOT, CMD_DUP, CMD_OUT, CMD_JMPZ, CMD_STO:
        need = 2'd1;
      default: need = 2'd0;
    endcase
  end

  always_comb begin
    ex_res   = '0;
    ex_res.status = ST_OK;
    count_d  = count_q;
    ex_we    = 1'b0;
    ex_wa    = nx_idx;
    ex_wd    = '0;
    ex_arith = 1'b0;
    ex_div   = 1'b0;
    ex_swap  = 1'b0;
    r        = '0;
    if (halted_q) begin
      ex_res.status = ST_HALTED;
    end else if (cmd_q > CMD_JMP) begin
      ex_res.status = ST_ILLEGAL;
    end else if (count_q < CNT_W'(need)) begin
      ex_res.status = ST_UNDERFLOW;
    end else begin
      case (cmd_q)
        CMD_PUSH: begin
          if (full) ex_res.status = ST_FULL;
          else begin
            ex_we = 1'b1; ex_wa = push_idx; ex_wd = opw; count_d = count_q + CNT_W'(1);
          end
        end
        CMD_ADD, CMD_SUB, CMD_GTR, CMD_LESS, CMD_EQ: begin
          case (cmd_q)
            CMD_ADD:  r = t + nx;
            CMD_SUB:  r = t - nx;
            CMD_GTR:  r = ($signed(nx) > $signed(t)) ? '0 : WORD_BITS'(1);
            CMD_LESS: r = ($signed(t) > $signed(nx)) ? '0 : WORD_BITS'(1);
            default:  r = (t == nx) ? WORD_BITS'(1) : '0;
          endcase
          ex_we = 1'b1; ex_wa = nx_idx; ex_wd = r; count_d = cnt_m1;
        end
        CMD_MUL: begin
          ex_arith = 1'b1; count_d = cnt_m1;
        end
        CMD_DIV: begin
          if (nx == '0) ex_res.status = ST_DIV_ZERO;
          else begin
            ex_arith = 1'b1; ex_div = 1'b1; count_d = cnt_m1;
          end
        end
        CMD_CLR: count_d = '0;
        CMD_SWAP: begin
          ex_we = 1'b1; ex_wa = top_idx; ex_wd = nx; ex_swap = 1'b1;
        end
        CMD_NEG, CMD_NOT: begin
          ex_we = 1'b1; ex_wa = top_idx; ex_wd = '0 - t;
        end
        CMD_DUP: begin
          if (full) ex_res.status = ST_FULL;
          else begin
            ex_we = 1'b1; ex_wa = push_idx; ex_wd = t; count_d = count_q + CNT_W'(1);
          end
        end
        CMD_OUT: begin
          ex_res.out_valid = 1'b1;
          ex_res.out_value = t_ext[OPND_W-1:0];
          count_d = cnt_m1;
        end
        CMD_HALT: ex_res.status = ST_HALTED;
        CMD_NOP: ;
        CMD_LDA: begin
          if (!addr_ok) ex_res.status = ST_BAD_ADDR;
          else if (full) ex_res.status = ST_FULL;
          else begin
            ex_we = 1'b1; ex_wa = push_idx; ex_wd = t; count_d = count_q + CNT_W'(1);
          end
        end
        CMD_JMPZ: begin
          if (t == '0) begin
            ex_res.jump_taken = 1'b1; ex_res.jump_label = opnd_q;
          end
          count_d = cnt_m1;
        end
        CMD_STO: begin
          if (!addr_ok) ex_res.status = ST_BAD_ADDR;
          else begin
            ex_we = 1'b1; ex_wa = sto_idx; ex_wd = t; count_d = cnt_m1;
          end
        end
        CMD_JMP: begin
          ex_res.jump_taken = 1'b1; ex_res.jump_label = opnd_q;
        end
        default: ;
      endcase
    end
    halted_d = halted_q || (ex_res.status != ST_OK);
    cnt_ext  = {{CNT_OUT_W{1'b0}}, count_d};
    ex_res.entry_count = cnt_ext[CNT_OUT_W-1:0];
    ex_res.is_halted   = halted_d;
  end

  always_comb begin
    we = 1'b0; wa = ex_wa; wd = ex_wd;
    fin_vld = 1'b0; fin_res = res_q;
    ar_req  = '{start: 1'b0, is_div: ex_div};
    state_d = state_q;
    case (state_q)
      S_CLEAR: begin
        we = 1'b1; wa = clr_idx_q; wd = '0;
        if (clr_idx_q == ADDR_W'(DEPTH - 1)) state_d = S_IDLE;
      end
      S_IDLE: if (instr_valid_i) state_d = S_EXEC;
      S_EXEC: begin
        we = ex_we;
        ar_req.start = ex_arith;
        if (ex_arith) state_d = S_ARITH;
        else if (ex_swap) state_d = S_SWAP2;
        else begin
          fin_vld = 1'b1; fin_res = ex_res;
        end
      end
      S_ARITH: begin
        we = ar_done; wa = top_idx; wd = ar_res;
        fin_vld = ar_done;
      end
      S_SWAP2: begin
        we = 1'b1; wa = nx_idx; wd = t_q;
        fin_vld = 1'b1;
      end
      S_HOLD: fin_vld = 1'b1;
      default: state_d = S_IDLE;
    endcase
    if (fin_vld) state_d = slot_free ? S_IDLE : S_HOLD;
  end

  assign slot_free = !res_vld_q || !res_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_CLEAR;
      clr_idx_q <= '0;
      count_q   <= '0;
      halted_q  <= 1'b0;
      res_vld_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (state_q == S_CLEAR) clr_idx_q <= clr_idx_q + ADDR_W'(1);
      if (state_q == S_IDLE && instr_valid_i) begin
        cmd_q  <= cmd_i;
        opnd_q <= operand_i;
      end
      if (state_q == S_EXEC) begin
        count_q  <= count_d;
        halted_q <= halted_d;
        t_q      <= t;
        res_q    <= ex_res;
      end else if (fin_vld && !slot_free) begin
        res_q <= fin_res;
      end
      if (slot_free) begin
        res_vld_q <= fin_vld;
        if (fin_vld) out_q <= fin_res;
      end
    end
  end

  assign instr_stall_o = (state_q != S_IDLE);
  assign res_valid_o   = res_vld_q;
  assign status_o      = out_q.status;
  assign out_valid_o   = out_q.out_valid;
  assign out_value_o   = out_q.out_value;
  assign jump_taken_o  = out_q.jump_taken;
  assign jump_label_o  = out_q.jump_label;
  assign entry_count_o = out_q.entry_count;
  assign is_halted_o   = out_q.is_halted;

  `SMEU_ASSERT(a_count_range, count_q <= CNT_W'(DEPTH))
  `SMEU_ASSERT(a_halt_sticky, halted_q |=> halted_q)
  `SMEU_ASSERT(a_err_halts, res_valid_o |-> (status_o == ST_OK || is_halted_o))
endmodule
`default_nettype wire

// ===== tb/sv/testbench.sv =====
// Testbench for the stack machine execute unit: predicted results checked in order
`default_nettype none
module testbench;
  import smeu_pkg::*;

  localparam int STACK_DEPTH = 256;
  localparam int N_RANDOM    = 1600;
  localparam int PAUSE_AT    = 800;
  localparam int HOLD_AT     = 300;
  localparam int HOLD_LEN    = 300;
  localparam int CYCLE_LIMIT = 1000000;

  typedef struct {
    logic [CMD_W-1:0]  cmd;
    logic [OPND_W-1:0] opnd;
    res_t              want;
  } word_t;

  logic                     clk_i = 1'b0;
  logic                     rst_ni = 1'b0;
  logic                     instr_valid_i = 1'b0;
  logic                     instr_stall_o;
  logic [CMD_W-1:0]         cmd_i = '0;
  logic signed [OPND_W-1:0] operand_i = '0;
  logic                     res_valid_o;
  logic                     res_stall_i = 1'b0;
  logic [STATUS_W-1:0]      status_o;
  logic                     out_valid_o;
  logic signed [OPND_W-1:0] out_value_o;
  logic                     jump_taken_o;
  logic signed [OPND_W-1:0] jump_label_o;
  logic [CNT_OUT_W-1:0]     entry_count_o;
  logic                     is_halted_o;

  stack_machine_execute_unit dut (.*);

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // shadow of the machine, advanced as words are queued
  logic [31:0] stack_mem [STACK_DEPTH];
  int          depth_cnt;
  bit          halted;

  word_t       pend_q [$];
  res_t        result_q [$];
  int          taken, got, errors, cycles;
  bit          took;
  int          gap, stall_left, hold_left;
  bit          hold_done;

  function automatic res_t exec_word(logic [CMD_W-1:0] c, logic [OPND_W-1:0] o);
    res_t        y;
    logic [31:0] t, nx, r, ua, ub, q;
    int          n, need;
    bit          addr_ok;
    y = '0;
    n = depth_cnt;
    t = '0;
    nx = '0;
    r = '0;
    addr_ok = !o[31] && o != 0 && o <= STACK_DEPTH;
    need = 0;
    if ((c >= CMD_ADD && c <= CMD_DIV) || c == CMD_SWAP || (c >= CMD_GTR && c <= CMD_EQ))
      need = 2;
    else if (c == CMD_NEG || c == CMD_DUP || c == CMD_OUT || c == CMD_NOT ||
             c == CMD_JMPZ || c == CMD_STO)
      need = 1;
    y.status = ST_OK;
    if (halted) y.status = ST_HALTED;
    else if (c > CMD_JMP) y.status = ST_ILLEGAL;
    else if (n < need) y.status = ST_UNDERFLOW;
    else begin
      if (n >= 1) t = stack_mem[n-1];
      if (n >= 2) nx = stack_mem[n-2];
      case (c)
        CMD_PUSH, CMD_DUP: begin
          if (n >= STACK_DEPTH) y.status = ST_FULL;
          else begin
            stack_mem[n] = (c == CMD_PUSH) ? o : t;
            n++;
          end
        end
        CMD_ADD, CMD_SUB, CMD_MUL, CMD_DIV, CMD_GTR, CMD_LESS, CMD_EQ: begin
          case (c)
            CMD_ADD: r = t + nx;
            CMD_SUB: r = t - nx;
            CMD_MUL: r = t * nx;
            CMD_DIV: begin
              if (nx == 0) y.status = ST_DIV_ZERO;
              else begin
                ua = t[31] ? -t : t;
                ub = nx[31] ? -nx : nx;
                q = ua / ub;
                r = (t[31] != nx[31]) ? -q : q;
              end
            end
            CMD_GTR: r = ($signed(nx) > $signed(t)) ? 32'd0 : 32'd1;
            CMD_LESS: r = ($signed(t) > $signed(nx)) ? 32'd0 : 32'd1;
            default: r = (t == nx) ? 32'd1 : 32'd0;
          endcase
          if (y.status == ST_OK) begin
            n--;
            stack_mem[n-1] = r;
          end
        end
        CMD_CLR: n = 0;
        CMD_SWAP: begin
          stack_mem[n-1] = nx;
          stack_mem[n-2] = t;
        end
        CMD_NEG, CMD_NOT: stack_mem[n-1] = -t;
        CMD_OUT: begin
          y.out_valid = 1'b1;
          y.out_value = t;
          n--;
        end
        CMD_HALT: y.status = ST_HALTED;
        CMD_NOP: ;
        CMD_LDA: begin
          if (!addr_ok) y.status = ST_BAD_ADDR;
          else if (n >= STACK_DEPTH) y.status = ST_FULL;
          else begin
            stack_mem[n] = stack_mem[o-1];
            n++;
          end
        end
        CMD_JMPZ: begin
          if (t == 0) begin
            y.jump_taken = 1'b1;
            y.jump_label = o;
          end
          n--;
        end
        CMD_STO: begin
          if (!addr_ok) y.status = ST_BAD_ADDR;
          else begin
            stack_mem[o-1] = t;
            n--;
          end
        end
        default: begin
          y.jump_taken = 1'b1;
          y.jump_label = o;
        end
      endcase
    end
    if (y.status != ST_OK) halted = 1'b1;
    depth_cnt = n;
    y.entry_count = n[CNT_OUT_W-1:0];
    y.is_halted = halted;
    return y;
  endfunction

  task automatic issue(logic [CMD_W-1:0] c, logic [OPND_W-1:0] o);
    word_t w;
    w.cmd = c;
    w.opnd = o;
    w.want = exec_word(c, o);
    pend_q.push_back(w);
  endtask

  // would this word keep the machine running
  function automatic bit is_safe(logic [CMD_W-1:0] c);
    int need;
    need = 0;
    if ((c >= CMD_ADD && c <= CMD_DIV) || c == CMD_SWAP || (c >= CMD_GTR && c <= CMD_EQ))
      need = 2;
    else if (c == CMD_NEG || c == CMD_DUP || c == CMD_OUT || c == CMD_NOT ||
             c == CMD_JMPZ || c == CMD_STO)
      need = 1;
    if (c == CMD_HALT || c > CMD_JMP || depth_cnt < need) return 1'b0;
    if ((c == CMD_PUSH || c == CMD_DUP || c == CMD_LDA) && depth_cnt >= STACK_DEPTH)
      return 1'b0;
    if (c == CMD_DIV && stack_mem[depth_cnt-2] == 0) return 1'b0;
    return 1'b1;
  endfunction

  function automatic logic [31:0] pick_val();
    case ($urandom_range(0, 7))
      0: return 32'd0;
      1: return 32'h8000_0000;
      2: return 32'h7fff_ffff;
      3: return 32'hffff_ffff;
      4: return $urandom_range(0, 9);
      default: return $urandom;
    endcase
  endfunction

  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if ((taken / 150) % 4 == 3) return 0;
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // stimulus
  initial begin
    cmd_e        fill_ops [3];
    cmd_e        drain_ops [10];
    logic [4:0]  c;
    logic [31:0] o;
    int          k, target, pick;
    bit          filling;
    fill_ops = '{CMD_PUSH, CMD_DUP, CMD_LDA};
    drain_ops = '{CMD_OUT, CMD_STO, CMD_JMPZ, CMD_ADD, CMD_SUB, CMD_MUL, CMD_DIV,
                  CMD_GTR, CMD_LESS, CMD_EQ};
    for (int i = 0; i < STACK_DEPTH; i++) stack_mem[i] = '0;
    depth_cnt = 0;
    halted = 1'b0;

    issue(CMD_PUSH, 32'hffff_ffff);
    issue(CMD_PUSH, 32'h8000_0000);
    issue(CMD_DIV, 32'h0);
    issue(CMD_PUSH, 32'h7fff_ffff);
    issue(CMD_ADD, 32'h0);
    issue(CMD_PUSH, 32'd5);
    issue(CMD_SWAP, 32'h0);
    issue(CMD_MUL, 32'h0);
    issue(CMD_DUP, 32'h0);
    issue(CMD_EQ, 32'h0);
    issue(CMD_PUSH, 32'd2);
    issue(CMD_GTR, 32'h0);
    issue(CMD_PUSH, 32'd0);
    issue(CMD_LESS, 32'h0);
    issue(CMD_NEG, 32'h0);
    issue(CMD_NOT, 32'h0);
    issue(CMD_STO, 32'd256);
    issue(CMD_LDA, 32'd256);
    issue(CMD_LDA, 32'd1);
    issue(CMD_PUSH, 32'd0);
    issue(CMD_JMPZ, 32'h8000_0000);
    issue(CMD_JMPZ, 32'hffff_ffff);
    issue(CMD_JMP, 32'h7fff_ffff);
    issue(CMD_NOP, 32'h0);
    issue(CMD_OUT, 32'h0);
    issue(CMD_CLR, 32'h0);

    k = 0;
    filling = 1'b1;
    target = STACK_DEPTH;
    while (k < N_RANDOM) begin
      pick = $urandom_range(0, 3);
      if (filling && pick != 0) c = fill_ops[$urandom_range(0, 2)];
      else if (!filling && pick != 0) c = drain_ops[$urandom_range(0, 9)];
      else c = CMD_W'($urandom_range(0, CMD_JMP));
      if (c == CMD_CLR && $urandom_range(0, 15) != 0) continue;
      if (!is_safe(c)) continue;
      o = (c == CMD_LDA || c == CMD_STO) ? $urandom_range(1, STACK_DEPTH) : pick_val();
      issue(c, o);
      k++;
      if (filling && depth_cnt >= target) begin
        filling = 1'b0;
        target = $urandom_range(0, 8);
      end else if (!filling && depth_cnt <= target) begin
        filling = 1'b1;
        target = ($urandom_range(0, 3) == 0) ? STACK_DEPTH : $urandom_range(4, 40);
      end
    end

    // one fault to stop the machine, then words against a halted machine
    case ($urandom_range(0, 5))
      0: issue(CMD_HALT, $urandom);
      1: issue(CMD_W'($urandom_range(CMD_JMP + 1, 31)), $urandom);
      2: begin
        issue(CMD_CLR, 32'h0);
        issue(CMD_ADD, 32'h0);
      end
      3: begin
        issue(CMD_PUSH, 32'd0);
        issue(CMD_PUSH, 32'd1);
        issue(CMD_DIV, 32'h0);
      end
      4: begin
        while (depth_cnt < STACK_DEPTH) issue(CMD_PUSH, $urandom);
        issue(CMD_PUSH, $urandom);
      end
      default: begin
        if (depth_cnt >= STACK_DEPTH) issue(CMD_OUT, 32'h0);
        case ($urandom_range(0, 2))
          0: issue(CMD_LDA, 32'd0);
          1: issue(CMD_LDA, 32'h8000_0000 | $urandom);
          default: issue(CMD_LDA, $urandom_range(STACK_DEPTH + 1, 32'h7fff_ffff));
        endcase
      end
    endcase
    for (int i = 0; i < 12; i++) issue(CMD_W'($urandom_range(0, 31)), $urandom);

    repeat (9) @(posedge clk_i);
    @(negedge clk_i) rst_ni <= 1'b1;

    while (pend_q.size() != 0 || result_q.size() != 0) @(posedge clk_i);
    repeat (80) @(posedge clk_i);
    if (errors == 0 && result_q.size() == 0) $display("== PASS ==");
    else $display("== FAIL ==");
    $finish;
  end

  // instruction driver
  always @(negedge clk_i) begin
    bit nv;
    nv = 1'b0;
    if (rst_ni) begin
      if (took) begin
        gap = gap_len();
        took = 1'b0;
      end
      if (gap > 0) gap--;
      else if (pend_q.size() != 0 && !(taken == PAUSE_AT && result_q.size() != 0)) begin
        nv = 1'b1;
        cmd_i <= pend_q[0].cmd;
        operand_i <= pend_q[0].opnd;
      end
    end
    instr_valid_i <= nv;
  end

  // result stall
  always @(negedge clk_i) begin
    bit ns;
    ns = 1'b0;
    if (hold_left > 0) begin
      hold_left--;
      ns = 1'b1;
    end else if (got >= HOLD_AT && !hold_done) begin
      hold_done = 1'b1;
      hold_left = HOLD_LEN;
      ns = 1'b1;
    end else if (stall_left > 0) begin
      stall_left--;
      ns = 1'b1;
    end else begin
      stall_left = gap_len();
      ns = stall_left > 0;
    end
    res_stall_i <= ns;
  end

  // acceptance and result check
  always @(posedge clk_i) begin
    res_t act, exp_r;
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end
    if (rst_ni && instr_valid_i && !instr_stall_o) begin
      result_q.push_back(pend_q[0].want);
      pend_q.pop_front();
      taken++;
      took = 1'b1;
    end
    if (rst_ni && res_valid_o && !res_stall_i) begin
      got++;
      act.status = status_e'(status_o);
      act.out_valid = out_valid_o;
      act.out_value = out_value_o;
      act.jump_taken = jump_taken_o;
      act.jump_label = jump_label_o;
      act.entry_count = entry_count_o;
      act.is_halted = is_halted_o;
      if (result_q.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected result word %p", act);
      end else begin
        exp_r = result_q.pop_front();
        if (act !== exp_r) begin
          errors++;
          if (errors <= 10)
            $display("result %0d: status %0d/%0d outv %b/%b val %h/%h jmp %b/%b lbl %h/%h cnt %0d/%0d halt %b/%b (exp/act)",
              got, exp_r.status, act.status, exp_r.out_valid, act.out_valid,
              exp_r.out_value, act.out_value, exp_r.jump_taken, act.jump_taken,
              exp_r.jump_label, act.jump_label, exp_r.entry_count, act.entry_count,
              exp_r.is_halted, act.is_halted);
        end
      end
    end
  end
endmodule
`default_nettype wire

// ===== sim.f =====
+incdir+rtl
rtl/smeu_pkg.sv
rtl/smeu_ram.sv
rtl/smeu_arith.sv
rtl/stack_machine_execute_unit.sv
tb/sv/testbench.sv
